[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while in reset
`define CHK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked implication, off while in reset
`define CHK_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// clocked implication on the next cycle, off while in reset
`define CHK_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[hdl/crt_pkg.sv]
package crt_pkg;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [1:0] MODE_OUT     = 2'd0;
	localparam logic [1:0] MODE_IN      = 2'd1;
	localparam logic [1:0] MODE_PENDING = 2'd2;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_FIELD = 2'd1;
	localparam logic [1:0] KIND_ROW   = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] token_kind;
		logic [7:0] token_byte;
	} out_beat_t;

endpackage

[hdl/csv_row_tokenizer.sv]
// CSV tokenizer: takes one byte or end-of-input marker per beat and returns at most one
// token per beat (data byte, end of field, end of field and row). A beat is taken every
// cycle at full rate while the output is not stalled; each beat passes an input register
// and then a result register before its token is on the output, and a beat that makes no
// token (opening or closing quote, carriage return, end of input with no open row) gives
// no output. The quote and row state is four flops updated once per beat, which sets
// the one beat per cycle rate. in_ready drops only while the result register holds a
// token that is not taken and a beat that makes a token waits in the input register.
module csv_row_tokenizer
	import crt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_beat,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_beat
);

	in_beat_t  beat_s1;
	logic      valid_s1;
	logic [1:0] mode_q, mode_d;
	logic      field_empty_q, field_empty_d;
	logic      row_open_q, row_open_d;
	out_beat_t out_beat_q;
	logic      out_valid_q;

	logic      emit;
	logic      unquoted;
	logic [1:0] kind;
	logic [7:0] data;
	logic      advance;
	logic [7:0] b;

	assign b = beat_s1.in_byte;

	always_comb begin
		mode_d        = mode_q;
		field_empty_d = field_empty_q;
		row_open_d    = row_open_q;
		emit          = 1'b0;
		unquoted      = 1'b0;
		kind          = KIND_DATA;
		data          = 8'd0;
		if (beat_s1.end_of_input) begin
			if (row_open_q) begin
				emit          = 1'b1;
				kind          = KIND_ROW;
				mode_d        = MODE_OUT;
				field_empty_d = 1'b1;
				row_open_d    = 1'b0;
			end
		end else begin
			row_open_d = 1'b1;
			case (mode_q)
				MODE_IN: begin
					if (b == CH_QUOTE) begin
						mode_d = MODE_PENDING;
					end else begin
						field_empty_d = 1'b0;
						emit          = 1'b1;
						data          = b;
					end
				end
				MODE_PENDING: begin
					if (b == CH_QUOTE) begin
						mode_d        = MODE_IN;
						field_empty_d = 1'b0;
						emit          = 1'b1;
						data          = CH_QUOTE;
					end else begin
						mode_d   = MODE_OUT;
						unquoted = 1'b1;
					end
				end
				default: begin
					mode_d   = MODE_OUT;
					unquoted = 1'b1;
				end
			endcase
			if (unquoted) begin
				if (b == CH_QUOTE && field_empty_q) begin
					mode_d = MODE_IN;
				end else if (b == CH_COMMA) begin
					field_empty_d = 1'b1;
					emit          = 1'b1;
					kind          = KIND_FIELD;
				end else if (b == CH_CR) begin
					emit = 1'b0;
				end else if (b == CH_LF) begin
					field_empty_d = 1'b1;
					row_open_d    = 1'b0;
					emit          = 1'b1;
					kind          = KIND_ROW;
				end else begin
					field_empty_d = 1'b0;
					emit          = 1'b1;
					data          = b;
				end
			end
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready || !emit);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			mode_q        <= MODE_OUT;
			field_empty_q <= 1'b1;
			row_open_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				mode_q        <= mode_d;
				field_empty_q <= field_empty_d;
				row_open_q    <= row_open_d;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_beat;
		end
		if (advance && emit) begin
			out_beat_q.token_kind <= kind;
			out_beat_q.token_byte <= data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

endmodule

[hdl/crt_checker.sv]
`include "assert_macros.svh"

module crt_checker
	import crt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_beat_t  in_beat,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_beat
);

	`CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat), "stalled token changed")
	`CHK_IMPLY(a_kind_legal, out_valid, out_beat.token_kind == KIND_DATA || out_beat.token_kind == KIND_FIELD || out_beat.token_kind == KIND_ROW, "illegal token kind")
	`CHK_IMPLY(a_delim_zero, out_valid && out_beat.token_kind != KIND_DATA, out_beat.token_byte == 8'd0, "delimiter token carries a byte")
	`CHK_IMPLY(a_cause, $rose(out_valid), $past(in_valid && in_ready, 2), "token without an accepted beat")

endmodule

bind csv_row_tokenizer crt_checker u_crt_checker (.*);
